[rtl/core/thbf_pkg.sv]
package thbf_pkg;

   // Fixed widths of the hashing datapath and the configuration register.
   localparam int HASH_W = 64;
   localparam int MUL_W  = 32;
   localparam int CFG_W  = 17;
   localparam int OUT_W  = 16;

   // Hash seeds and the Q0.64 multiplicative hashing constants.
   localparam logic [HASH_W-1:0] DJB_SEED  = 64'd5381;
   localparam logic [HASH_W-1:0] SDBM_SEED = 64'd0;
   localparam logic [HASH_W-1:0] PHI_Q64   = 64'h9E3779B97F4A7C15;
   localparam logic [HASH_W-1:0] PHI10_Q64 = 64'd1140071481932319848;

   // Reset value of the filter size register.
   localparam logic [CFG_W-1:0] FILTER_BITS_RESET = 17'd65536;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // One input transaction.
   typedef struct packed {
      logic [1:0]        func;
      logic signed [7:0] key_byte;
      logic              byte_valid;
      logic              last_byte;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic             present;
      logic [OUT_W-1:0] first_index;
      logic [OUT_W-1:0] second_index;
   } rsp_type;

   // Operands for the shared multiplier.
   typedef struct packed {
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

   // Access strobes for the bit store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_LL,
      ST_MUL_HL,
      ST_MUL_LH,
      ST_FRAC,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_INDEX,
      ST_DIV_RECIP,
      ST_DIV_BACK,
      ST_DIV_REM,
      ST_READ_A,
      ST_WRITE_A,
      ST_READ_B,
      ST_WRITE_B,
      ST_RESPOND
   } state_type;

endpackage

[rtl/core/thbf_mul.sv]
module thbf_mul (
   input  logic                         clock,
   input  thbf_pkg::mul_req_type        mul_req,
   output logic [thbf_pkg::HASH_W-1:0]  prod
);
   import thbf_pkg::*;

   logic [HASH_W-1:0] prod_in;
   logic [HASH_W-1:0] prod_ff;

   // One 32 by 32 unsigned product per cycle, registered.
   assign prod_in = HASH_W'(mul_req.op_a) * HASH_W'(mul_req.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/core/thbf_hash.sv]
module thbf_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  thbf_pkg::req_type            req,
   input  logic                         key_done,
   output logic [thbf_pkg::HASH_W-1:0]  first_hash,
   output logic [thbf_pkg::HASH_W-1:0]  second_hash
);
   import thbf_pkg::*;

   logic [HASH_W-1:0] first_hash_ff;
   logic [HASH_W-1:0] first_hash_in;
   logic [HASH_W-1:0] second_hash_ff;
   logic [HASH_W-1:0] second_hash_in;
   logic [HASH_W-1:0] byte_ext;

   // The character is sign extended before it joins the hashes.
   assign byte_ext = {{(HASH_W-8){req.key_byte[7]}}, req.key_byte};

   // djb2 is h*33 + c and sdbm is h*65599 + c, both as shifts and adds.
   always_comb begin
      first_hash_in  = first_hash_ff;
      second_hash_in = second_hash_ff;
      if (key_done) begin
         first_hash_in  = DJB_SEED;
         second_hash_in = SDBM_SEED;
      end else if (accept && req.byte_valid) begin
         first_hash_in  = (first_hash_ff << 5) + first_hash_ff + byte_ext;
         second_hash_in = (second_hash_ff << 16) + (second_hash_ff << 6)
                          - second_hash_ff + byte_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_hash_ff  <= DJB_SEED;
         second_hash_ff <= SDBM_SEED;
      end else begin
         first_hash_ff  <= first_hash_in;
         second_hash_ff <= second_hash_in;
      end
   end

   assign first_hash  = first_hash_ff;
   assign second_hash = second_hash_ff;

endmodule

[rtl/core/thbf_store.sv]
module thbf_store #(
   parameter int WORDS     = 1024,
   parameter int WORD_BITS = 64,
   parameter int ADDR_W    = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  thbf_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]       addr,
   input  logic [WORD_BITS-1:0]    wdata,
   output logic [WORD_BITS-1:0]    rdata,
   output logic                    clearing
);
   import thbf_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 clear_active_ff;
   logic                 clear_active_in;
   logic [ADDR_W-1:0]    clear_addr_ff;
   logic [ADDR_W-1:0]    clear_addr_in;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // The clearing pass walks every word once after reset.
   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
      end
   end

   // The clearing pass owns the write port while it runs.
   assign wr_en   = clear_active_ff | ctl.wr_en;
   assign wr_addr = clear_active_ff ? clear_addr_ff : addr;
   assign wr_data = clear_active_ff ? '0 : wdata;

   // Memory with one write port and a registered read port; both use addr outside the clearing pass.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clearing = clear_active_ff;

endmodule

[rtl/core/thbf_ctrl.sv]
module thbf_ctrl #(
   parameter int MAX_BITS  = 65536,
   parameter int WORD_BITS = 64,
   parameter int ADDR_W    = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  thbf_pkg::req_type            req,
   input  logic [thbf_pkg::CFG_W-1:0]   filter_bits,
   input  logic [thbf_pkg::HASH_W-1:0]  first_hash,
   input  logic [thbf_pkg::HASH_W-1:0]  second_hash,
   input  logic [thbf_pkg::HASH_W-1:0]  prod,
   input  logic [WORD_BITS-1:0]         rdata,
   output thbf_pkg::mul_req_type        mul_req,
   output thbf_pkg::store_ctl_type      store_ctl,
   output logic [ADDR_W-1:0]            store_addr,
   output logic [WORD_BITS-1:0]         store_wdata,
   output logic                         key_done,
   output logic                         busy,
   output logic                         rsp_valid,
   output thbf_pkg::rsp_type            rsp_data
);
   import thbf_pkg::*;

   localparam int IDX_W     = $clog2(MAX_BITS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int DIV_SHIFT = IDX_W + BIT_W;
   localparam longint unsigned DIV_RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
   localparam logic [MUL_W-1:0] DIV_RECIP  = MUL_W'(DIV_RECIP_FULL);
   localparam logic [MUL_W-1:0] WORD_CONST = MUL_W'(WORD_BITS);
   localparam logic [MUL_W-1:0] MAX_CONST  = MUL_W'(MAX_BITS);

   state_type            state_ff, state_in;
   logic                 sel_ff, sel_in;
   logic [1:0]           func_ff, func_in;
   logic [HASH_W-1:0]    acc_ff, acc_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]    quot_ff, quot_in;
   logic [ADDR_W-1:0]    word_a_ff, word_a_in;
   logic [ADDR_W-1:0]    word_b_ff, word_b_in;
   logic [BIT_W-1:0]     bit_a_ff, bit_a_in;
   logic [BIT_W-1:0]     bit_b_ff, bit_b_in;
   logic [OUT_W-1:0]     index_a_ff, index_a_in;
   logic [OUT_W-1:0]     index_b_ff, index_b_in;
   logic                 hit_a_ff, hit_a_in;
   logic                 present_ff, present_in;

   logic [HASH_W-1:0]    hash_sel;
   logic [HASH_W-1:0]    const_sel;
   logic [MUL_W-1:0]     scale_op;
   logic [HASH_W-1:0]    scale_sum;
   logic [HASH_W-1:0]    quot_full;
   logic [IDX_W-1:0]     rem_full;
   logic [BIT_W-1:0]     rem_bit;
   logic                 is_write_op;
   logic [BIT_W-1:0]     bit_sel;
   logic [WORD_BITS-1:0] bit_mask;

   // The first pass works on the djb2 hash, the second on the sdbm hash.
   assign hash_sel  = sel_ff ? second_hash : first_hash;
   assign const_sel = sel_ff ? PHI10_Q64 : PHI_Q64;

   // Filter size in use: zero acts as one, sizes above the store are capped.
   always_comb begin
      scale_op = MUL_W'(filter_bits);
      if (filter_bits == '0) begin
         scale_op = MUL_W'(1);
      end else if (MUL_W'(filter_bits) > MAX_CONST) begin
         scale_op = MAX_CONST;
      end
   end

   // Index arithmetic taps on the multiplier result.
   assign scale_sum = prod + acc_ff;
   assign quot_full = prod >> DIV_SHIFT;
   assign rem_full  = idx_ff - prod[IDX_W-1:0];
   assign rem_bit   = rem_full[BIT_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.last_byte) begin
               state_in = ST_MUL_LL;
            end
         end
         ST_MUL_LL:    state_in = ST_MUL_HL;
         ST_MUL_HL:    state_in = ST_MUL_LH;
         ST_MUL_LH:    state_in = ST_FRAC;
         ST_FRAC:      state_in = ST_SCALE_LO;
         ST_SCALE_LO:  state_in = ST_SCALE_HI;
         ST_SCALE_HI:  state_in = ST_INDEX;
         ST_INDEX:     state_in = ST_DIV_RECIP;
         ST_DIV_RECIP: state_in = ST_DIV_BACK;
         ST_DIV_BACK:  state_in = ST_DIV_REM;
         ST_DIV_REM:   state_in = sel_ff ? ST_READ_A : ST_MUL_LL;
         ST_READ_A:    state_in = ST_WRITE_A;
         ST_WRITE_A:   state_in = ST_READ_B;
         ST_READ_B:    state_in = ST_WRITE_B;
         ST_WRITE_B:   state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs: multiplier operands, store access, key_done, busy and the result strobe.
   assign is_write_op = (func_ff == FUNC_INSERT) || (func_ff == FUNC_DELETE);
   assign bit_sel     = (state_ff == ST_WRITE_B) ? bit_b_ff : bit_a_ff;
   assign bit_mask    = WORD_BITS'(1) << bit_sel;

   always_comb begin
      mul_req         = '0;
      store_ctl       = '0;
      store_addr      = word_a_ff;
      store_wdata     = (func_ff == FUNC_INSERT) ? (rdata | bit_mask) : (rdata & ~bit_mask);
      key_done        = 1'b0;
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_MUL_LL: begin
            mul_req.op_a = hash_sel[MUL_W-1:0];
            mul_req.op_b = const_sel[MUL_W-1:0];
         end
         ST_MUL_HL: begin
            mul_req.op_a = hash_sel[HASH_W-1:MUL_W];
            mul_req.op_b = const_sel[MUL_W-1:0];
         end
         ST_MUL_LH: begin
            mul_req.op_a = hash_sel[MUL_W-1:0];
            mul_req.op_b = const_sel[HASH_W-1:MUL_W];
         end
         ST_SCALE_LO: begin
            mul_req.op_a = acc_ff[MUL_W-1:0];
            mul_req.op_b = scale_op;
         end
         ST_SCALE_HI: begin
            mul_req.op_a = acc_ff[HASH_W-1:MUL_W];
            mul_req.op_b = scale_op;
         end
         ST_DIV_RECIP: begin
            mul_req.op_a = MUL_W'(idx_ff);
            mul_req.op_b = DIV_RECIP;
         end
         ST_DIV_BACK: begin
            mul_req.op_a = MUL_W'(quot_full[ADDR_W-1:0]);
            mul_req.op_b = WORD_CONST;
         end
         ST_READ_A: begin
            store_ctl.rd_en = 1'b1;
         end
         ST_WRITE_A: begin
            store_ctl.wr_en = is_write_op;
         end
         ST_READ_B: begin
            store_ctl.rd_en = 1'b1;
            store_addr      = word_b_ff;
         end
         ST_WRITE_B: begin
            store_ctl.wr_en = is_write_op;
            store_addr      = word_b_ff;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            key_done  = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rsp_data.present      = present_ff;
   assign rsp_data.first_index  = index_a_ff;
   assign rsp_data.second_index = index_b_ff;

   // Datapath register updates, one step of the index computation a cycle.
   always_comb begin
      sel_in     = sel_ff;
      func_in    = func_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      quot_in    = quot_ff;
      word_a_in  = word_a_ff;
      word_b_in  = word_b_ff;
      bit_a_in   = bit_a_ff;
      bit_b_in   = bit_b_ff;
      index_a_in = index_a_ff;
      index_b_in = index_b_ff;
      hit_a_in   = hit_a_ff;
      present_in = present_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.last_byte) begin
               sel_in  = 1'b0;
               func_in = req.func;
            end
         end
         ST_MUL_HL: begin
            acc_in = prod;
         end
         ST_MUL_LH, ST_FRAC: begin
            acc_in = acc_ff + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
         end
         ST_SCALE_HI: begin
            acc_in = {{MUL_W{1'b0}}, prod[HASH_W-1:MUL_W]};
         end
         ST_INDEX: begin
            idx_in = scale_sum[IDX_W+MUL_W-1:MUL_W];
         end
         ST_DIV_BACK: begin
            quot_in = quot_full[ADDR_W-1:0];
         end
         ST_DIV_REM: begin
            if (sel_ff) begin
               word_b_in  = quot_ff;
               bit_b_in   = rem_bit;
               index_b_in = OUT_W'(idx_ff);
            end else begin
               word_a_in  = quot_ff;
               bit_a_in   = rem_bit;
               index_a_in = OUT_W'(idx_ff);
               sel_in     = 1'b1;
            end
         end
         ST_WRITE_A: begin
            hit_a_in = rdata[bit_a_ff];
         end
         ST_WRITE_B: begin
            present_in = (func_ff == FUNC_QUERY) && hit_a_ff && rdata[bit_b_ff];
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
         func_ff  <= FUNC_INSERT;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         func_ff  <= func_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      idx_ff     <= idx_in;
      quot_ff    <= quot_in;
      word_a_ff  <= word_a_in;
      word_b_ff  <= word_b_in;
      bit_a_ff   <= bit_a_in;
      bit_b_ff   <= bit_b_in;
      index_a_ff <= index_a_in;
      index_b_ff <= index_b_in;
      hit_a_ff   <= hit_a_in;
      present_ff <= present_in;
   end

endmodule

[rtl/core/two_hash_bloom_filter.sv]
// A key byte that is not the last of its key is absorbed into the hashes; busy stays low.
// A last byte runs two index passes (fourteen products through the shared 32x32
// multiplier), two store reads and, for insert and delete, two store writes, then
// raises the result strobe. Busy stays high through the strobe, so the next is taken after.
// After reset the bit store is cleared one word a cycle with busy high; hashes return
// to their seeds, filter_bits to 65536.
module two_hash_bloom_filter #(
   parameter int MAX_BITS  = 65536,
   parameter int WORD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  thbf_pkg::req_type           req_data,
   output logic                        rsp_valid,
   output thbf_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [thbf_pkg::CFG_W-1:0]  csr_wr_data
);
   import thbf_pkg::*;

   localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   logic [CFG_W-1:0]     filter_bits_ff;
   logic [CFG_W-1:0]     filter_bits_in;
   logic                 accept;
   logic                 ctrl_busy;
   logic                 clearing;
   logic                 key_done;
   logic [HASH_W-1:0]    first_hash;
   logic [HASH_W-1:0]    second_hash;
   logic [HASH_W-1:0]    prod;
   mul_req_type          mul_req;
   store_ctl_type        store_ctl;
   logic [ADDR_W-1:0]    store_addr;
   logic [WORD_BITS-1:0] store_wdata;
   logic [WORD_BITS-1:0] store_rdata;

   // Filter size register.
   assign filter_bits_in = csr_wr_en ? csr_wr_data : filter_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= FILTER_BITS_RESET;
      end else begin
         filter_bits_ff <= filter_bits_in;
      end
   end

   // A transaction is taken when the sequencer is idle and the store is clear.
   assign busy   = ctrl_busy | clearing;
   assign accept = start & ~busy;

   thbf_hash u_hash (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .key_done    (key_done),
      .first_hash  (first_hash),
      .second_hash (second_hash)
   );

   thbf_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   thbf_store #(
      .WORDS     (STORE_WORDS),
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .addr     (store_addr),
      .wdata    (store_wdata),
      .rdata    (store_rdata),
      .clearing (clearing)
   );

   thbf_ctrl #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .filter_bits (filter_bits_ff),
      .first_hash  (first_hash),
      .second_hash (second_hash),
      .prod        (prod),
      .rdata       (store_rdata),
      .mul_req     (mul_req),
      .store_ctl   (store_ctl),
      .store_addr  (store_addr),
      .store_wdata (store_wdata),
      .key_done    (key_done),
      .busy        (ctrl_busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

[tb/two_hash_bloom_filter_tb.sv]
`timescale 1ns / 1ps

module two_hash_bloom_filter_tb;
   import thbf_pkg::*;

   localparam int FILTER_MAX   = 65536;
   localparam int KEY_MAX      = 8;
   localparam int POOL_SIZE    = 16;
   localparam int NUM_PHASES   = 10;
   localparam int TARGET_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_SIZE  = -1;

   // The func field has one code that the block leaves unused.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Keeps its own copy of the hashes, the filter size and the bit store, and
   // holds the results that are still to come, oldest first.
   class bloom_scoreboard;
      logic [HASH_W-1:0] djb_hash;
      logic [HASH_W-1:0] sdbm_hash;
      logic [CFG_W-1:0]  filter_bits;
      bit                store_bits [FILTER_MAX];
      rsp_type           expected_rsp [$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       hits;

      function new();
         djb_hash    = DJB_SEED;
         sdbm_hash   = SDBM_SEED;
         filter_bits = FILTER_BITS_RESET;
         foreach (store_bits[i]) store_bits[i] = 1'b0;
         mismatches  = 0;
         checked     = 0;
         hits        = 0;
      endfunction

      function void set_filter_bits(input logic [CFG_W-1:0] value);
         filter_bits = value;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // Scales a Q0.64 fraction by the filter size; the fraction is truncated.
      function logic [HASH_W-1:0] scale_fraction(input logic [HASH_W-1:0] frac,
                                                 input logic [HASH_W-1:0] size);
         logic [HASH_W-1:0] hi_part;
         logic [HASH_W-1:0] lo_part;
         hi_part = frac >> 32;
         lo_part = frac & 64'h0000_0000_FFFF_FFFF;
         return (hi_part * size + ((lo_part * size) >> 32)) >> 32;
      endfunction

      // Absorbs one accepted transaction; the last item of a key yields a result.
      function void note_request(input req_type req);
         logic [HASH_W-1:0] ext_byte;
         logic [HASH_W-1:0] size;
         logic [HASH_W-1:0] frac;
         logic [HASH_W-1:0] first_idx;
         logic [HASH_W-1:0] second_idx;
         rsp_type           rsp;
         if (req.byte_valid) begin
            ext_byte  = {{56{req.key_byte[7]}}, req.key_byte};
            djb_hash  = djb_hash * 64'd33 + ext_byte;
            sdbm_hash = sdbm_hash * 64'd65599 + ext_byte;
         end
         if (!req.last_byte) return;

         // Sizes out of range are clamped to one bit and to the full store.
         size = filter_bits;
         if (size == 0) size = 1;
         if (size > FILTER_MAX) size = FILTER_MAX;
         frac       = djb_hash * PHI_Q64;
         first_idx  = scale_fraction(frac, size);
         frac       = sdbm_hash * PHI10_Q64;
         second_idx = scale_fraction(frac, size);

         rsp.present = 1'b0;
         case (req.func)
            FUNC_INSERT: begin
               store_bits[first_idx[15:0]]  = 1'b1;
               store_bits[second_idx[15:0]] = 1'b1;
            end
            FUNC_DELETE: begin
               store_bits[first_idx[15:0]]  = 1'b0;
               store_bits[second_idx[15:0]] = 1'b0;
            end
            FUNC_QUERY: begin
               rsp.present = store_bits[first_idx[15:0]] && store_bits[second_idx[15:0]];
               if (rsp.present) hits++;
            end
            default: begin
               // The unused code touches nothing but still reports the indexes.
            end
         endcase
         rsp.first_index  = first_idx[OUT_W-1:0];
         rsp.second_index = second_idx[OUT_W-1:0];
         expected_rsp.push_back(rsp);

         djb_hash  = DJB_SEED;
         sdbm_hash = SDBM_SEED;
      endfunction

      // Compares one result transaction with the oldest one expected.
      function void check_result(input rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, actual present %0b first %0d second %0d",
                     $time, got.present, got.first_index, got.second_index);
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         if (got.present !== want.present) begin
            mismatches++;
            $display("%0t: present mismatch, expected %0b, actual %0b",
                     $time, want.present, got.present);
         end
         if (got.first_index !== want.first_index) begin
            mismatches++;
            $display("%0t: first_index mismatch, expected %0d, actual %0d",
                     $time, want.first_index, got.first_index);
         end
         if (got.second_index !== want.second_index) begin
            mismatches++;
            $display("%0t: second_index mismatch, expected %0d, actual %0d",
                     $time, want.second_index, got.second_index);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   bloom_scoreboard sb;
   logic [7:0]      key_buf [KEY_MAX];
   logic [7:0]      key_pool [POOL_SIZE][KEY_MAX];
   int              pool_len [POOL_SIZE];
   int              size_plan [NUM_PHASES] = '{1, 0, 2, 64, 131071, 65535, 1000, 100,
                                               RANDOM_SIZE, 65536};
   bit              no_idle;
   int unsigned     item_count;
   int unsigned     key_count;
   int unsigned     sizes_written;
   int unsigned     cycle_count = 0;

   two_hash_bloom_filter uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Every result strobe is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // Watchdog against a hung handshake or a missing result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_hash_bloom_filter_tb failed");
         $finish;
      end
   end

   // Presents one transaction and holds it until the block takes it.
   task automatic send_item(input req_type req);
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      sb.note_request(req);
   endtask

   // Random gap after a transaction: mostly none or short, a few long.
   task automatic idle_gap();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A transaction without a character inside a key; the hashes must not move.
   task automatic send_noise();
      req_type req;
      req.func       = 2'($urandom_range(0, 3));
      req.key_byte   = 8'($urandom_range(0, 255));
      req.byte_valid = 1'b0;
      req.last_byte  = 1'b0;
      send_item(req);
      idle_gap();
   endtask

   // Sends the key held in key_buf; the operation rides on the last item, which is
   // either the last character or a separate item without a character.
   task automatic send_key(input int len, input logic [1:0] op, input bit invalid_end);
      req_type req;
      bit      is_last;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_noise();
         is_last        = (i == len - 1) && !invalid_end;
         req.func       = is_last ? op : 2'($urandom_range(0, 3));
         req.key_byte   = key_buf[i];
         req.byte_valid = 1'b1;
         req.last_byte  = is_last;
         send_item(req);
         item_count++;
         idle_gap();
      end
      if (len == 0 || invalid_end) begin
         req.func       = op;
         req.key_byte   = 8'($urandom_range(0, 255));
         req.byte_valid = 1'b0;
         req.last_byte  = 1'b1;
         send_item(req);
         item_count++;
         idle_gap();
      end
      key_count++;
   endtask

   task automatic directed_key(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input int len,
                               input logic [1:0] op, input bit invalid_end);
      key_buf[0] = b0;
      key_buf[1] = b1;
      key_buf[2] = b2;
      send_key(len, op, invalid_end);
   endtask

   // Waits until every expected result has come and the block is idle again.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_filter_bits(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_filter_bits(value);
      sizes_written++;
   endtask

   task automatic refresh_pool_key(input int slot);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) pool_len[slot] = 0;
      else if (pick < 85) pool_len[slot] = $urandom_range(1, 4);
      else pool_len[slot] = $urandom_range(5, KEY_MAX);
      for (int i = 0; i < KEY_MAX; i++) key_pool[slot][i] = 8'($urandom_range(0, 255));
   endtask

   // One key from the pool, so that queries and deletes find earlier inserts.
   task automatic random_key();
      int         slot;
      int         pick;
      logic [1:0] op;
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 9) == 0) refresh_pool_key(slot);
      pick = $urandom_range(0, 99);
      if (pick < 40) op = FUNC_INSERT;
      else if (pick < 75) op = FUNC_QUERY;
      else if (pick < 90) op = FUNC_DELETE;
      else op = FUNC_UNUSED;
      for (int i = 0; i < KEY_MAX; i++) key_buf[i] = key_pool[slot][i];
      send_key(pool_len[slot], op, $urandom_range(0, 9) == 0);
      // Now and then the sender holds off until the block has caught up.
      if ($urandom_range(0, 49) == 0) drain();
   endtask

   initial begin
      int          size_value;
      int unsigned phase_end;
      sb            = new();
      reset         <= 1'b1;
      start         <= 1'b0;
      req_data      <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      no_idle       = 1'b0;
      item_count    = 0;
      key_count     = 0;
      sizes_written = 0;
      for (int s = 0; s < POOL_SIZE; s++) refresh_pool_key(s);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // The store is cleared after reset with busy high.
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      // Directed keys at the reset size: empty keys, extreme bytes, every operation.
      directed_key(8'h00, 8'h00, 8'h00, 0, FUNC_INSERT, 1'b0);
      directed_key(8'h00, 8'h00, 8'h00, 0, FUNC_QUERY, 1'b0);
      directed_key(8'h80, 8'h00, 8'h00, 1, FUNC_INSERT, 1'b0);
      directed_key(8'h80, 8'h00, 8'h00, 1, FUNC_QUERY, 1'b0);
      directed_key(8'h7F, 8'h00, 8'h00, 1, FUNC_QUERY, 1'b0);
      directed_key(8'h80, 8'h00, 8'h00, 1, FUNC_DELETE, 1'b0);
      directed_key(8'h80, 8'h00, 8'h00, 1, FUNC_QUERY, 1'b0);
      directed_key(8'h00, 8'h00, 8'h00, 1, FUNC_UNUSED, 1'b0);
      directed_key(8'h00, 8'h00, 8'h00, 1, FUNC_QUERY, 1'b0);
      directed_key(8'hFF, 8'h7F, 8'h80, 3, FUNC_INSERT, 1'b1);
      directed_key(8'hFF, 8'h7F, 8'h80, 3, FUNC_QUERY, 1'b0);
      send_noise();
      directed_key(8'h55, 8'hAA, 8'h00, 2, FUNC_INSERT, 1'b0);
      directed_key(8'h55, 8'hAA, 8'h00, 2, FUNC_QUERY, 1'b1);
      directed_key(8'h7F, 8'h7F, 8'h7F, 3, FUNC_UNUSED, 1'b0);
      directed_key(8'hFF, 8'h00, 8'h00, 1, FUNC_INSERT, 1'b0);

      // Random keys under a series of filter sizes, the extremes among them.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         size_value = (size_plan[p] == RANDOM_SIZE) ? $urandom_range(3, FILTER_MAX)
                                                     : size_plan[p];
         write_filter_bits(CFG_W'(size_value));
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_end = item_count + TARGET_ITEMS / NUM_PHASES;
         while (item_count < phase_end) random_key();
      end
      drain();

      $display("Run covered %0d keys in %0d items over %0d filter sizes after the reset size.",
               key_count, item_count, sizes_written);
      $display("%0d results checked, %0d queries found both bits set.", sb.checked, sb.hits);
      if (sb.mismatches == 0) begin
         $display("two_hash_bloom_filter_tb passed");
      end else begin
         $display("two_hash_bloom_filter_tb failed");
      end
      $finish;
   end

endmodule
